### rtl/bdpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdpc_pkg
// Shared types and constants for the byte delta prefix code encoder.
// ----------------------------------------------------------------------------
package bdpc_pkg;

    localparam int MAX_BEATS  = 3;    // most output bytes one item can cause
    localparam int CODE_W     = 15;   // longest code: 2*6+3 bits
    localparam int PEND_W     = 7;    // pending bits held between items
    localparam int WIN_W      = PEND_W + CODE_W;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       stream_end;
    } t_beat;

    typedef struct packed {
        t_beat [MAX_BEATS-1:0] beats;
        logic  [1:0]           count;
        logic  [PEND_W-1:0]    next_bits;
        logic  [2:0]           next_cnt;
    } t_code;

endpackage : bdpc_pkg
`default_nettype wire

### rtl/bdpc_coder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdpc_coder
// Delta-codes one byte against the previous one (a first byte passes raw),
// packs the code behind the pending bits and splits it into up to three bytes.
// ----------------------------------------------------------------------------
module bdpc_coder
    import bdpc_pkg::*;
(
    input  wire logic [7:0]        i_sample,
    input  wire logic              i_first,
    input  wire logic              i_last,
    input  wire logic [7:0]        i_prev,
    input  wire logic [PEND_W-1:0] i_pend_bits,
    input  wire logic [2:0]        i_pend_cnt,
    output t_code                  o_code
);

    logic             sgn;
    logic [7:0]       mag;
    logic [2:0]       len;
    logic [CODE_W-1:0] code;
    logic [4:0]       n_bits;
    logic [1:0]       n_full;
    logic [2:0]       rem;
    logic [WIN_W-1:0] win;
    logic [7:0]       tail;
    logic             flush;

    assign sgn = (i_sample >= i_prev);
    assign mag = sgn ? (i_sample - i_prev) : (i_prev - i_sample);

    // length prefix; a magnitude of 256 or more cannot occur on 8 bits
    always_comb begin
        casez (mag[7:3])
            5'b1????: len = 3'd6;
            5'b01???: len = 3'd5;
            5'b001??: len = 3'd4;
            5'b0001?: len = 3'd3;
            5'b00001: len = 3'd2;
            default:  len = 3'd1;
        endcase
    end

    // code bits MSB-first: len copies of s, not-s, then len+2 bits of |d| LSB-first
    always_comb begin
        logic [3:0] idx;
        logic [3:0] pos;
        code = '0;
        for (int j = 0; j < CODE_W; j++) begin
            pos = 4'(j);
            idx = pos - {1'b0, len} - 4'd1;
            if (pos < {1'b0, len})
                code[CODE_W-1-j] = sgn;
            else if (pos == {1'b0, len})
                code[CODE_W-1-j] = ~sgn;
            else if (pos < ({1'b0, len} << 1) + 4'd3)
                code[CODE_W-1-j] = mag[idx[2:0]];
        end
    end

    assign n_bits = {2'b00, i_pend_cnt} + ({2'b00, len} << 1) + 5'd3;
    assign n_full = n_bits[4:3];
    assign rem    = n_bits[2:0];

    // align the oldest pending bit to the top of the window
    assign win = ({i_pend_bits, {CODE_W{1'b0}}} << (3'd7 - i_pend_cnt))
               | ({{PEND_W{1'b0}}, code} << (3'd7 - i_pend_cnt));

    always_comb begin
        case (n_full)
            2'd0:    tail = win[WIN_W-1 -: 8];
            2'd1:    tail = win[WIN_W-9 -: 8];
            default: tail = {win[WIN_W-17:0], 2'b00};
        endcase
    end

    assign flush = i_last && (rem != 3'd0);

    always_comb begin
        o_code = '0;
        if (i_first) begin
            o_code.beats[0] = '{data: i_sample, run_last: 1'b1, stream_end: i_last};
            o_code.count    = 2'd1;
        end else begin
            o_code.beats[0].data = win[WIN_W-1 -: 8];
            o_code.beats[1].data = win[WIN_W-9 -: 8];
            o_code.beats[2].data = tail;
            o_code.count         = n_full + {1'b0, flush};
            for (int k = 0; k < MAX_BEATS; k++) begin
                o_code.beats[k].run_last   = (2'(k) == o_code.count - 2'd1);
                o_code.beats[k].stream_end = i_last;
            end
            if (!flush) begin
                o_code.next_bits = PEND_W'(tail >> (4'd8 - {1'b0, rem}));
                o_code.next_cnt  = rem;
            end
        end
    end

endmodule : bdpc_coder
`default_nettype wire

### rtl/bdpc_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdpc_fifo
// Byte queue: takes up to three beats per cycle, hands out one unless stalled.
// ----------------------------------------------------------------------------
module bdpc_fifo
    import bdpc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [1:0]            i_push_n,
    input  wire t_beat [MAX_BEATS-1:0] i_push_beats,
    output logic                       o_room,
    output logic                       o_valid,
    output t_beat                      o_beat,
    input  wire logic                  i_stall
);

    t_beat              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [FIFO_AW:0]   r_count;
    logic               pop;

    assign o_valid = (r_count != '0);
    assign o_beat  = r_mem[r_rd_ptr];
    assign pop     = o_valid && !i_stall;
    assign o_room  = (r_count <= (FIFO_AW+1)'(FIFO_DEPTH - MAX_BEATS));

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_BEATS; k++) begin
            if (2'(k) < i_push_n)
                r_mem[r_wr_ptr + FIFO_AW'(k)] <= i_push_beats[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_AW'(i_push_n);
            if (pop)
                r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= r_count + (FIFO_AW+1)'(i_push_n) - (FIFO_AW+1)'(pop);
        end
    end

endmodule : bdpc_fifo
`default_nettype wire

### rtl/byte_delta_prefix_code_encoder.sv
// An item is held in the input register, then its beats in the byte queue.
// Throughput: one item per cycle while the byte queue has room for three
// beats; the output drains one byte per cycle while i_stall is low, and an
// item produces at most three bytes. Reset (synchronous, active low) clears
// the previous sample, the pending bits and the queue.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// byte_delta_prefix_code_encoder
// Delta coder with a length prefix code, bits packed MSB-first into bytes.
// ----------------------------------------------------------------------------
module byte_delta_prefix_code_encoder
    import bdpc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_sample,
    input  wire logic       i_first,
    input  wire logic       i_last,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_run_last,
    output logic            o_stream_end
);

    logic              r_in_valid;
    logic [7:0]        r_sample;
    logic              r_first, r_last;
    logic [7:0]        r_prev;
    logic [PEND_W-1:0] r_pend_bits;
    logic [2:0]        r_pend_cnt;

    t_code code;
    t_beat out_beat;
    logic  room;
    logic  advance;
    logic  accept;
    logic [1:0] push_n;

    assign advance = r_in_valid && room;
    assign o_stall = r_in_valid && !room;
    assign accept  = i_valid && !o_stall;
    assign push_n  = advance ? code.count : 2'd0;

    bdpc_coder u_coder (
        .i_sample    (r_sample),
        .i_first     (r_first),
        .i_last      (r_last),
        .i_prev      (r_prev),
        .i_pend_bits (r_pend_bits),
        .i_pend_cnt  (r_pend_cnt),
        .o_code      (code)
    );

    bdpc_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_n     (push_n),
        .i_push_beats (code.beats),
        .o_room       (room),
        .o_valid      (o_valid),
        .o_beat       (out_beat),
        .i_stall      (i_stall)
    );

    assign o_out_byte   = out_beat.data;
    assign o_run_last   = out_beat.run_last;
    assign o_stream_end = out_beat.stream_end;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample <= i_sample;
            r_first  <= i_first;
            r_last   <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_prev      <= '0;
            r_pend_bits <= '0;
            r_pend_cnt  <= '0;
        end else begin
            if (accept)
                r_in_valid <= 1'b1;
            else if (advance)
                r_in_valid <= 1'b0;
            // commit coder state as the item's beats enter the queue
            if (advance) begin
                r_prev      <= r_sample;
                r_pend_bits <= code.next_bits;
                r_pend_cnt  <= code.next_cnt;
            end
        end
    end

    a_last_flushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_last |=> r_pend_cnt == 3'd0)
        else $error("pending bits left after a last item");

    a_first_raw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_first |-> push_n == 2'd1 && code.beats[0].data == r_sample)
        else $error("first item did not yield exactly its raw byte");

    a_first_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_first |=> r_pend_cnt == 3'd0 && r_prev == $past(r_sample))
        else $error("coder state wrong after a first item");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_n != 2'd0 |-> room)
        else $error("beats pushed without queue room");

endmodule : byte_delta_prefix_code_encoder
`default_nettype wire

### sim/byte_delta_prefix_code_encoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_delta_prefix_code_encoder_test
// Drives sample bytes in stream order, encodes each one alongside the block
// and checks every packed output beat in order against the expected bytes.
// ----------------------------------------------------------------------------
module byte_delta_prefix_code_encoder_test;
    import bdpc_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 200;
    localparam int DRAIN_CYCLES   = 16;

    typedef struct {
        logic [7:0] data;
        logic       first;
        logic       last;
        logic       drain;  // hold this beat until all coded bytes are out
    } t_item;

    typedef enum int {STALL_NONE, STALL_COIN, STALL_EVERY3, STALL_HEAVY} t_stall_mode;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic [7:0] i_sample     = 8'h00;
    logic       i_first      = 1'b0;
    logic       i_last       = 1'b0;
    logic       i_stall      = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic       o_run_last;
    logic       o_stream_end;

    // encoder state mirrored on the testbench side
    logic [7:0] prev_data = 8'h00;
    logic [6:0] acc_bits  = '0;
    int         acc_cnt   = 0;
    logic [7:0] out_bytes[$];

    t_item      sample_q[$];
    t_beat      coded_beats_q[$];
    int         item_total  = 0;
    int         items_taken = 0;
    int         errors      = 0;
    int         burst_left  = 1;
    int         gap_left    = 0;
    int         idle_cycles = 0;
    int         stall_left  = 0;
    t_stall_mode stall_mode = STALL_NONE;

    byte_delta_prefix_code_encoder u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_sample     (i_sample),
        .i_first      (i_first),
        .i_last       (i_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_run_last   (o_run_last),
        .o_stream_end (o_stream_end)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic void add_code_bit(input logic b);
        logic [7:0] acc;
        acc = {acc_bits, b};
        if (acc_cnt == 7) begin
            out_bytes.push_back(acc);
            acc_bits = '0;
            acc_cnt  = 0;
        end else begin
            acc_bits = acc[6:0];
            acc_cnt++;
        end
    endfunction

    // Encode one accepted sample and queue the beats it should produce.
    task automatic encode_sample(input logic [7:0] data, input logic first,
                                 input logic last);
        int    mag;
        int    len;
        int    i;
        logic  sgn;
        t_beat b;
        out_bytes.delete();
        if (first) begin
            acc_bits = '0;
            acc_cnt  = 0;
            out_bytes.push_back(data);
        end else begin
            sgn = (data >= prev_data);
            mag = sgn ? int'(data) - int'(prev_data) : int'(prev_data) - int'(data);
            len = (mag < 8)   ? 1 :
                  (mag < 16)  ? 2 :
                  (mag < 32)  ? 3 :
                  (mag < 64)  ? 4 :
                  (mag < 128) ? 5 :
                  (mag < 256) ? 6 : 7;
            repeat (len) add_code_bit(sgn);
            add_code_bit(!sgn);
            for (i = 0; i < len + 2; i++) add_code_bit(mag[i]);
        end
        prev_data = data;
        // pad the partial byte with zeros at the end of a stream
        if (last && acc_cnt != 0) begin
            out_bytes.push_back(8'((int'(acc_bits) << (8 - acc_cnt)) & 255));
            acc_bits = '0;
            acc_cnt  = 0;
        end
        for (i = 0; i < out_bytes.size(); i++) begin
            b.data       = out_bytes[i];
            b.run_last   = (i == out_bytes.size() - 1);
            b.stream_end = last;
            coded_beats_q.push_back(b);
        end
    endtask

    function automatic void add_item(input int data, input logic first, input logic last,
                                     input logic drain);
        t_item it;
        it.data  = 8'(data);
        it.first = first;
        it.last  = last;
        it.drain = drain;
        sample_q.push_back(it);
        item_total++;
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_item nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                encode_sample(i_sample, i_first, i_last);
                items_taken++;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (sample_q.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (sample_q[0].drain && coded_beats_q.size() != 0) begin
                    i_valid <= 1'b0;
                end else begin
                    nxt = sample_q.pop_front();
                    i_sample <= nxt.data;
                    i_first  <= nxt.first;
                    i_last   <= nxt.last;
                    i_valid  <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
    end

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_left = $urandom_range(10, 150);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            STALL_NONE:   i_stall <= 1'b0;
            STALL_COIN:   i_stall <= ($urandom_range(0, 1) == 1);
            STALL_EVERY3: i_stall <= (stall_left % 3 == 0);
            default:      i_stall <= ($urandom_range(0, 6) != 0);
        endcase
    end

    // monitor
    always @(posedge i_clk) begin
        t_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (coded_beats_q.size() == 0) begin
                $display({"%0t: unexpected beat: expected none, ",
                          "got out_byte=%02h run_last=%0b stream_end=%0b"},
                         $time, o_out_byte, o_run_last, o_stream_end);
                errors++;
            end else begin
                want = coded_beats_q.pop_front();
                if (o_out_byte !== want.data) begin
                    $display("%0t: out_byte mismatch: expected %02h, got %02h",
                             $time, want.data, o_out_byte);
                    errors++;
                end
                if (o_run_last !== want.run_last) begin
                    $display("%0t: run_last mismatch: expected %0b, got %0b",
                             $time, want.run_last, o_run_last);
                    errors++;
                end
                if (o_stream_end !== want.stream_end) begin
                    $display("%0t: stream_end mismatch: expected %0b, got %0b",
                             $time, want.stream_end, o_stream_end);
                    errors++;
                end
            end
        end
    end

    // watchdog: any accepted beat on either side resets the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d beats still expected",
                     $time, coded_beats_q.size());
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int n_random;
        int stream_len;
        int k;
        int cls;
        int mag;
        int smp;
        int gen_prev;
        logic lead_first;
        logic close_last;
        logic up;
        logic fst;
        logic lst;

        // directed: no first mark after reset, every length class, both signs
        add_item(8'h05, 1'b0, 1'b0, 1'b0);
        add_item(8'h00, 1'b1, 1'b0, 1'b0);
        add_item(8'h07, 1'b0, 1'b0, 1'b0);
        add_item(8'h0F, 1'b0, 1'b0, 1'b0);
        add_item(8'h1E, 1'b0, 1'b0, 1'b0);
        add_item(8'h2E, 1'b0, 1'b0, 1'b0);
        add_item(8'h4D, 1'b0, 1'b0, 1'b0);
        add_item(8'h6D, 1'b0, 1'b0, 1'b0);
        add_item(8'hAC, 1'b0, 1'b0, 1'b0);
        add_item(8'hEC, 1'b0, 1'b0, 1'b0);
        add_item(8'h6D, 1'b0, 1'b0, 1'b0);
        add_item(8'hED, 1'b0, 1'b0, 1'b0);
        add_item(8'h00, 1'b0, 1'b0, 1'b0);
        add_item(8'hFF, 1'b0, 1'b0, 1'b0);
        add_item(8'h00, 1'b0, 1'b0, 1'b0);
        add_item(8'h00, 1'b0, 1'b1, 1'b0);
        // first and last together, then a stream that ends byte aligned
        add_item(8'hA5, 1'b1, 1'b1, 1'b1);
        add_item(8'h40, 1'b1, 1'b0, 1'b0);
        add_item(8'h43, 1'b0, 1'b0, 1'b0);
        add_item(8'h63, 1'b0, 1'b1, 1'b0);
        // first mark while bits are pending drops them
        add_item(8'h10, 1'b0, 1'b0, 1'b0);
        add_item(8'hC3, 1'b1, 1'b0, 1'b0);
        add_item(8'h80, 1'b0, 1'b1, 1'b0);

        // random streams: mostly well formed, with some noise items
        n_random = 0;
        gen_prev = 8'h80;
        while (n_random < RANDOM_ITEMS) begin
            stream_len = $urandom_range(1, 12);
            lead_first = ($urandom_range(0, 9) != 0);
            close_last = ($urandom_range(0, 9) != 0);
            for (k = 0; k < stream_len; k++) begin
                fst = (k == 0) && lead_first;
                lst = (k == stream_len - 1) && close_last;
                if ($urandom_range(0, 9) == 0) begin
                    smp = $urandom_range(0, 255);
                    fst = ($urandom_range(0, 3) == 0);
                    lst = ($urandom_range(0, 3) == 0);
                end else begin
                    cls = $urandom_range(0, 6);
                    if (cls == 6)
                        mag = 0;
                    else if (cls == 0)
                        mag = $urandom_range(0, 7);
                    else
                        mag = $urandom_range(4 << cls, (8 << cls) - 1);
                    up = ($urandom_range(0, 1) == 1);
                    if (up && gen_prev + mag > 255) up = 1'b0;
                    if (!up && gen_prev < mag) up = 1'b1;
                    if (up && gen_prev + mag > 255)
                        smp = $urandom_range(0, 255);
                    else
                        smp = up ? gen_prev + mag : gen_prev - mag;
                end
                add_item(smp, fst, lst, (n_random == 0) || ($urandom_range(0, 29) == 0));
                gen_prev = smp;
                n_random++;
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (items_taken != item_total) @(posedge i_clk);
        while (coded_beats_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
